### design/pvd_pkg.sv
// Shared types and constants for the polynomial valley detector.
`default_nettype none

package pvd_pkg;

    // Number of polynomial coefficients (degree 6).
    localparam int unsigned NUM_COEF = 7;

    // Width of one coefficient register and of the evaluated value.
    localparam int unsigned COEF_W = 48;
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned X_W    = 16;
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned FRAC_X = 15;
    localparam int unsigned PROD_W = ACC_W + X_W;

    // Register map of the configuration port.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_LIMIT = 3'd7;

    // Reset value of confirm_limit.
    localparam logic [3:0] CONFIRM_LIMIT_RST = 4'd2;

    // Sample indexes at or above this count are clamped on report.
    localparam int unsigned MAX_POINTS = 1024;
    localparam logic [IDX_W-1:0] CLAMP_IDX = IDX_W'(MAX_POINTS - 1);

    // Horner step counter.
    localparam logic [2:0] STEP_FIRST = 3'd5;
    localparam logic [2:0] STEP_LAST  = 3'd0;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MUL    = 4'b0010,
        ST_ADD    = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

endpackage : pvd_pkg

`default_nettype wire

### design/poly_valley_detector_top.sv
// Top level of the polynomial valley detector: Horner evaluation and descent tracking.
//
// Usage:
//   Configuration: write coef_0..coef_6 (index 0..6, signed Q16.32 in the low
//   48 bits of cfg_data) and confirm_limit (index 7, low 4 bits) with a
//   one-cycle cfg_write pulse while the block is idle.
//   Input channel (in_valid/in_ready): one transfer per sample carrying
//   x_pos, sample_index, run_first and run_last. in_ready is high only
//   while the sequencer is idle; a new sample waits until the last is done.
//   The polynomial runs through one shared 64x16 multiplier: six Horner
//   steps, each a multiply state then an add state (shift, saturate and add
//   the next coefficient), then a decision state and a return to idle.
//   Output channel (out_valid/out_ready): zero or one transfer per sample,
//   found = 1 with the confirming index, or found = 0 with index 0 when a
//   run ends with no valley. The result sits in an output register, so the
//   next sample is accepted and evaluated while it waits; that sample then
//   holds in its decision state until the receiver takes the waiting result.
//   Reset (rst_n low, asynchronous): coefficients clear, confirm_limit
//   returns to 2, descent state clears and any pending result is dropped.
`default_nettype none

module poly_valley_detector_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [47:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [15:0]  x_pos,
    input  wire logic [9:0]          sample_index,
    input  wire logic                run_first,
    input  wire logic                run_last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     found,
    output logic [9:0]               min_index
);
    import pvd_pkg::*;

    // Configuration registers.
    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    logic [3:0]               limit_reg;

    // Sequencer and datapath.
    state_t                   state_reg, state_next;
    logic [2:0]               step_reg, step_next;
    logic signed [X_W-1:0]    x_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     first_reg;
    logic                     last_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg;

    // Descent tracking state.
    logic signed [ACC_W-1:0]  ref_reg, ref_next;
    logic                     desc_reg, desc_next;
    logic [3:0]               rise_reg, rise_next;
    logic                     done_reg, done_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         min_index_reg, min_index_next;

    logic                     in_xfer;
    logic                     out_free;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W:0]    shifted;
    logic signed [ACC_W-1:0]  scaled;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  horner;
    logic [4:0]               rise_inc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign min_index = min_index_reg;

    // Configuration writes; index 7 sets confirm_limit, any other index a coefficient.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
            limit_reg <= CONFIRM_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_CONFIRM_LIMIT)
            begin
                limit_reg <= cfg_data[3:0];
            end
            else
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Shared multiplier: exact signed product of the accumulator and x.
    assign prod = PROD_W'(acc_reg) * PROD_W'(x_reg);

    // Floor by arithmetic shift, clamp to 64 bits, then add the coefficient
    // and clamp again.
    always_comb
    begin
        shifted = prod_reg[PROD_W-1:FRAC_X];
        if (shifted[ACC_W] != shifted[ACC_W-1])
        begin
            scaled = shifted[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            scaled = shifted[ACC_W-1:0];
        end
        sum = {scaled[ACC_W-1], scaled} + (ACC_W+1)'(coef_reg[step_reg]);
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            horner = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            horner = sum[ACC_W-1:0];
        end
    end

    assign rise_inc = {1'b0, rise_reg} + 5'd1;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        ref_next       = ref_reg;
        desc_next      = desc_reg;
        rise_next      = rise_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        min_index_next = min_index_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    acc_next   = coef_reg[NUM_COEF-1];
                    step_next  = STEP_FIRST;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next = horner;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    step_next  = step_reg - 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DECIDE:
            begin
                // Hold until the output register can take a result.
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (first_reg)
                    begin
                        ref_next  = acc_reg;
                        desc_next = 1'b0;
                        rise_next = '0;
                        done_next = last_reg;
                        if (last_reg)
                        begin
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                            min_index_next = '0;
                        end
                    end
                    else if (!done_reg)
                    begin
                        if (desc_reg && (acc_reg > ref_reg) &&
                            (rise_inc > {1'b0, limit_reg}))
                        begin
                            // Valley confirmed: report once and close the run.
                            rise_next      = '0;
                            done_next      = 1'b1;
                            out_valid_next = 1'b1;
                            found_next     = 1'b1;
                            min_index_next = (32'(idx_reg) >= MAX_POINTS) ?
                                             CLAMP_IDX : idx_reg;
                        end
                        else
                        begin
                            if (desc_reg && (acc_reg > ref_reg))
                            begin
                                rise_next = rise_inc[3:0];
                            end
                            else
                            begin
                                rise_next = '0;
                            end
                            if (!desc_reg)
                            begin
                                desc_next = (acc_reg < ref_reg);
                                ref_next  = acc_reg;
                            end
                            else if (acc_reg < ref_reg)
                            begin
                                ref_next = acc_reg;
                            end
                            if (last_reg)
                            begin
                                done_next      = 1'b1;
                                out_valid_next = 1'b1;
                                found_next     = 1'b0;
                                min_index_next = '0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_FIRST;
            ref_reg       <= '0;
            desc_reg      <= 1'b0;
            rise_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ref_reg       <= ref_next;
            desc_reg      <= desc_next;
            rise_reg      <= rise_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg     <= x_pos;
            idx_reg   <= sample_index;
            first_reg <= run_first;
            last_reg  <= run_last;
        end
        acc_reg       <= acc_next;
        prod_reg      <= prod;
        found_reg     <= found_next;
        min_index_reg <= min_index_next;
    end

endmodule : poly_valley_detector_top

`default_nettype wire
